@@ src/yolr_pkg.sv @@
// ----------------------------------------------------------------------------
// yolr_pkg
// Shared types and constants of the young/old LRU frame replacer.
// ----------------------------------------------------------------------------
package yolr_pkg;

  localparam int DefNumFrames = 64;
  localparam int CntW         = 32;
  localparam int FrameW       = 6;
  localparam int TotalW       = 7;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_PIN    = 2'd1,
    CMD_UNPIN  = 2'd2,
    CMD_VICTIM = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LST_NONE  = 2'd0,
    LST_OLD   = 2'd1,
    LST_YOUNG = 2'd2
  } lst_t;

  typedef enum logic [2:0] {
    SW_PUSH_OLD   = 3'd0,
    SW_MOVE_YOUNG = 3'd1,
    SW_PROMOTE    = 3'd2,
    SW_UNLINK     = 3'd3,
    SW_FIND       = 3'd4
  } sweep_t;

  typedef struct packed {
    logic   clr;
    logic   vld;
    sweep_t mode;
    lst_t   sel;
  } sweep_ctl_t;

  typedef struct packed {
    cmd_t              command;
    logic [FrameW-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic              victim_found;
    logic [FrameW-1:0] victim_frame;
    logic [TotalW-1:0] evictable_total;
  } out_item_t;

endpackage

@@ src/young_old_lru_frame_replacer.sv @@
// ----------------------------------------------------------------------------
// young_old_lru_frame_replacer
// Buffer-frame replacer with old and young recency lists (midpoint insertion).
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   input   | start, busy, in_item           | taken when start && !busy
//   result  | out_valid, out_item            | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data | write when valid && ready
//
// Pin, unpin, out-of-range and non-promoting accesses pass through read, decide
// and fix. Accesses that reorder a list add one rank sweep of the frame table
// through the rank unit, one entry per cycle, before the fix.
// Victim request: read, decide, a search sweep, a pick and, when found, an unlink
// sweep; the pick goes straight to the fix when no frame can be evicted.
// After reset every frame table entry is cleared in turn; busy is high meanwhile.
// Results cannot be stalled; the next item may start while one is shown.
// ----------------------------------------------------------------------------
module young_old_lru_frame_replacer #(
  parameter int NUM_FRAMES = yolr_pkg::DefNumFrames
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  yolr_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output yolr_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [yolr_pkg::CntW-1:0]  cfg_data
);
  import yolr_pkg::*;

  localparam int AW  = $clog2(NUM_FRAMES);
  localparam int IW  = AW + 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int FW  = ((AW > FrameW) ? AW : FrameW) + 1;
  localparam int EW  = AW + 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_SWEEP,
    ST_PICK,
    ST_FIX
  } state_t;

  state_t          state_r;
  logic [IW-1:0]   idx_r;
  logic            pv_r;
  logic [AW-1:0]   pa_r;
  cmd_t            cmd_r;
  logic [AW-1:0]   fa_r;
  logic            inr_r;
  sweep_t          mode_r;
  lst_t            sel_r;
  logic [AW-1:0]   ref_r;
  logic            write_f_r;
  logic            stamp_wr_r;
  logic            fix_mark_r;
  lst_t            fix_lst_r;
  logic [AW-1:0]   fix_rank_r;
  logic            found_r;
  logic [FrameW-1:0] victim_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] thr_r;
  logic [CW-1:0]   evc_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [EW-1:0]   ent_mem [NUM_FRAMES];
  logic [CntW-1:0] stamp_mem [NUM_FRAMES];
  logic [EW-1:0]   ent_rd_r;
  logic [CntW-1:0] stamp_rd_r;

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [EW-1:0]   mem_wd;
  logic [AW-1:0]   mem_ra;
  logic            stamp_we;

  logic            rd_mark;
  lst_t            rd_lst;
  logic [AW-1:0]   rd_rank;
  logic [FW-1:0]   frame_fw;
  logic            accept;
  logic [CntW-1:0] delta;

  sweep_ctl_t      ctl;
  logic [AW-1:0]   new_rank;
  logic            upd;
  logic            old_hit, yng_hit;
  logic [AW-1:0]   old_frame, old_rank, yng_frame, yng_rank;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign frame_fw  = FW'(in_item.frame_number);

  assign rd_mark = ent_rd_r[EW-1];
  assign rd_lst  = lst_t'(ent_rd_r[AW+1:AW]);
  assign rd_rank = ent_rd_r[AW-1:0];
  assign delta   = cnt_r - stamp_rd_r;

  assign ctl.clr  = (state_r == ST_DECIDE);
  assign ctl.vld  = (state_r == ST_SWEEP) && pv_r;
  assign ctl.mode = mode_r;
  assign ctl.sel  = sel_r;

  yolr_rank_unit #(
    .AW(AW)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ref_rank  (ref_r),
    .ent_lst   (rd_lst),
    .ent_rank  (rd_rank),
    .ent_mark  (rd_mark),
    .ent_frame (pa_r),
    .new_rank  (new_rank),
    .upd       (upd),
    .old_hit   (old_hit),
    .old_frame (old_frame),
    .old_rank  (old_rank),
    .yng_hit   (yng_hit),
    .yng_frame (yng_frame),
    .yng_rank  (yng_rank)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fa_r;
    mem_wd = {fix_mark_r, fix_lst_r, fix_rank_r};
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_r[AW-1:0];
        mem_wd = '0;
      end
      ST_SWEEP: begin
        mem_we = upd;
        mem_wa = pa_r;
        mem_wd = {rd_mark, rd_lst, new_rank};
      end
      ST_FIX: begin
        mem_we = write_f_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_ra   = (state_r == ST_SWEEP) ? idx_r[AW-1:0] : fa_r;
  assign stamp_we = (state_r == ST_FIX) && stamp_wr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem[mem_wa] <= mem_wd;
    end
    ent_rd_r <= ent_mem[mem_ra];
    if (stamp_we) begin
      stamp_mem[fa_r] <= cnt_r;
    end
    stamp_rd_r <= stamp_mem[fa_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      cnt_r       <= '0;
      evc_r       <= '0;
      out_valid_r <= 1'b0;
      write_f_r   <= 1'b0;
      stamp_wr_r  <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_r + IW'(1);
          if (idx_r == IW'(NUM_FRAMES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r      <= in_item.command;
            fa_r       <= frame_fw[AW-1:0];
            inr_r      <= (frame_fw < FW'(NUM_FRAMES));
            write_f_r  <= 1'b0;
            stamp_wr_r <= 1'b0;
            found_r    <= 1'b0;
            victim_r   <= '0;
            if (in_item.command == CMD_ACCESS) begin
              cnt_r <= cnt_r + CntW'(1);
            end
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          idx_r      <= '0;
          pv_r       <= 1'b0;
          fix_mark_r <= rd_mark;
          fix_lst_r  <= rd_lst;
          fix_rank_r <= rd_rank;
          ref_r      <= rd_rank;
          sel_r      <= rd_lst;
          state_r    <= ST_FIX;
          case (cmd_r)
            CMD_ACCESS: begin
              if (inr_r) begin
                case (rd_lst)
                  LST_NONE: begin
                    mode_r     <= SW_PUSH_OLD;
                    fix_lst_r  <= LST_OLD;
                    fix_rank_r <= '0;
                    write_f_r  <= 1'b1;
                    stamp_wr_r <= 1'b1;
                    state_r    <= ST_SWEEP;
                  end
                  LST_YOUNG: begin
                    mode_r     <= SW_MOVE_YOUNG;
                    fix_rank_r <= '0;
                    write_f_r  <= 1'b1;
                    state_r    <= ST_SWEEP;
                  end
                  LST_OLD: begin
                    if (delta >= thr_r) begin
                      mode_r     <= SW_PROMOTE;
                      fix_lst_r  <= LST_YOUNG;
                      fix_rank_r <= '0;
                      write_f_r  <= 1'b1;
                      state_r    <= ST_SWEEP;
                    end
                  end
                  default: begin
                    write_f_r <= 1'b0;
                  end
                endcase
              end
            end
            CMD_PIN: begin
              if (inr_r) begin
                fix_mark_r <= 1'b0;
                write_f_r  <= 1'b1;
                if (rd_mark) begin
                  evc_r <= evc_r - CW'(1);
                end
              end
            end
            CMD_UNPIN: begin
              if (inr_r) begin
                fix_mark_r <= 1'b1;
                write_f_r  <= 1'b1;
                if (!rd_mark) begin
                  evc_r <= evc_r + CW'(1);
                end
              end
            end
            default: begin
              mode_r  <= SW_FIND;
              state_r <= ST_SWEEP;
            end
          endcase
        end
        ST_SWEEP: begin
          pv_r <= (idx_r < IW'(NUM_FRAMES));
          pa_r <= idx_r[AW-1:0];
          if (idx_r < IW'(NUM_FRAMES)) begin
            idx_r <= idx_r + IW'(1);
          end else begin
            state_r <= (mode_r == SW_FIND) ? ST_PICK : ST_FIX;
          end
        end
        ST_PICK: begin
          idx_r      <= '0;
          pv_r       <= 1'b0;
          mode_r     <= SW_UNLINK;
          fix_mark_r <= 1'b0;
          fix_lst_r  <= LST_NONE;
          fix_rank_r <= '0;
          state_r    <= ST_FIX;
          if (old_hit || yng_hit) begin
            fa_r      <= old_hit ? old_frame : yng_frame;
            ref_r     <= old_hit ? old_rank : yng_rank;
            sel_r     <= old_hit ? LST_OLD : LST_YOUNG;
            victim_r  <= FrameW'(FW'(old_hit ? old_frame : yng_frame));
            found_r   <= 1'b1;
            write_f_r <= 1'b1;
            evc_r     <= evc_r - CW'(1);
            state_r   <= ST_SWEEP;
          end
        end
        ST_FIX: begin
          out_valid_r                <= 1'b1;
          out_item_r.victim_found    <= found_r;
          out_item_r.victim_frame    <= victim_r;
          out_item_r.evictable_total <= TotalW'(evc_r);
          state_r                    <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_sweep_spares_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && mem_we) |-> (mem_wa != fa_r))
    else $error("rank sweep rewrote the commanded frame");

  a_victim_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && (old_hit || yng_hit)) |-> (evc_r != '0))
    else $error("victim chosen while no frame is evictable");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (evc_r <= CW'(NUM_FRAMES)))
    else $error("evictable count out of range");

  a_result_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_FIX && state_r == ST_IDLE))
    else $error("result strobe outside command completion");

endmodule

@@ src/yolr_rank_unit.sv @@
// ----------------------------------------------------------------------------
// yolr_rank_unit
// Per-entry rank compare/adjust unit used by every list sweep; also tracks
// the back-most evictable frame of each list during a victim search.
// ----------------------------------------------------------------------------
module yolr_rank_unit #(
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  yolr_pkg::sweep_ctl_t ctl,
  input  logic [AW-1:0]       ref_rank,
  input  yolr_pkg::lst_t      ent_lst,
  input  logic [AW-1:0]       ent_rank,
  input  logic                ent_mark,
  input  logic [AW-1:0]       ent_frame,
  output logic [AW-1:0]       new_rank,
  output logic                upd,
  output logic                old_hit,
  output logic [AW-1:0]       old_frame,
  output logic [AW-1:0]       old_rank,
  output logic                yng_hit,
  output logic [AW-1:0]       yng_frame,
  output logic [AW-1:0]       yng_rank
);
  import yolr_pkg::*;

  logic          gt;
  logic          lt;
  logic          inc;
  logic          dec;
  logic          old_hit_r, old_hit_nxt;
  logic          yng_hit_r, yng_hit_nxt;
  logic [AW-1:0] old_frame_r, old_rank_r;
  logic [AW-1:0] yng_frame_r, yng_rank_r;

  assign gt = ent_rank > ref_rank;
  assign lt = ent_rank < ref_rank;

  always_comb begin
    inc = 1'b0;
    dec = 1'b0;
    case (ctl.mode)
      SW_PUSH_OLD: begin
        inc = (ent_lst == LST_OLD);
      end
      SW_MOVE_YOUNG: begin
        inc = (ent_lst == LST_YOUNG) && lt;
      end
      SW_PROMOTE: begin
        dec = (ent_lst == LST_OLD) && gt;
        inc = (ent_lst == LST_YOUNG);
      end
      SW_UNLINK: begin
        dec = (ent_lst == ctl.sel) && gt;
      end
      default: begin
        inc = 1'b0;
        dec = 1'b0;
      end
    endcase
  end

  assign new_rank = inc ? ent_rank + AW'(1) : ent_rank - AW'(1);
  assign upd      = ctl.vld && (inc || dec);

  assign old_hit_nxt = ctl.vld && (ctl.mode == SW_FIND) && ent_mark &&
                       (ent_lst == LST_OLD) && (!old_hit_r || ent_rank > old_rank_r);
  assign yng_hit_nxt = ctl.vld && (ctl.mode == SW_FIND) && ent_mark &&
                       (ent_lst == LST_YOUNG) && (!yng_hit_r || ent_rank > yng_rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      old_hit_r <= 1'b0;
      yng_hit_r <= 1'b0;
    end else begin
      if (old_hit_nxt) begin
        old_hit_r <= 1'b1;
      end
      if (yng_hit_nxt) begin
        yng_hit_r <= 1'b1;
      end
    end
    if (old_hit_nxt) begin
      old_frame_r <= ent_frame;
      old_rank_r  <= ent_rank;
    end
    if (yng_hit_nxt) begin
      yng_frame_r <= ent_frame;
      yng_rank_r  <= ent_rank;
    end
  end

  assign old_hit   = old_hit_r;
  assign old_frame = old_frame_r;
  assign old_rank  = old_rank_r;
  assign yng_hit   = yng_hit_r;
  assign yng_frame = yng_frame_r;
  assign yng_rank  = yng_rank_r;

endmodule

@@ dv/yolr_checker.sv @@
// ----------------------------------------------------------------------------
// yolr_checker
// Watches the command, result and threshold channels of the young/old LRU
// frame replacer. It keeps its own copy of the frame lists, predicts the
// result of every accepted item and compares each result strobe with the
// oldest prediction.
// ----------------------------------------------------------------------------
module yolr_checker #(
  parameter int NF = yolr_pkg::DefNumFrames
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  yolr_pkg::in_item_t         in_item,
  input  logic                       out_valid,
  input  yolr_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [yolr_pkg::CntW-1:0]  cfg_data,
  output int                         fail_cnt,
  output int                         pending,
  output int                         result_cnt,
  output int                         evicted_cnt
);
  import yolr_pkg::*;

  lst_t             frame_list  [NF];
  int               frame_rank  [NF];
  logic [CntW-1:0]  frame_stamp [NF];
  bit               frame_evict [NF];
  logic [CntW-1:0]  access_cnt;
  logic [CntW-1:0]  promo_thr;

  out_item_t        expected_results [$];
  out_item_t        oldest;
  int               n_fail  = 0;
  int               n_res   = 0;
  int               n_evict = 0;

  function automatic void clear_lists();
    for (int g = 0; g < NF; g++) begin
      frame_list[g]  = LST_NONE;
      frame_rank[g]  = 0;
      frame_stamp[g] = '0;
      frame_evict[g] = 1'b0;
    end
    access_cnt = '0;
    promo_thr  = '0;
  endfunction

  function automatic void move_to_front(int f, lst_t which);
    for (int g = 0; g < NF; g++) begin
      if (frame_list[g] == which) frame_rank[g]++;
    end
    frame_list[f] = which;
    frame_rank[f] = 0;
  endfunction

  function automatic void drop_frame(int f);
    lst_t which;
    int   r;
    which = frame_list[f];
    r     = frame_rank[f];
    if (which == LST_NONE) return;
    for (int g = 0; g < NF; g++) begin
      if (frame_list[g] == which && frame_rank[g] > r) frame_rank[g]--;
    end
    frame_list[f] = LST_NONE;
    frame_rank[f] = 0;
  endfunction

  // evictable frame nearest the back of a list, -1 if none
  function automatic int rearmost_evictable(lst_t which);
    int best;
    int best_rank;
    best      = -1;
    best_rank = 0;
    for (int g = 0; g < NF; g++) begin
      if (frame_list[g] == which && frame_evict[g]) begin
        if (best < 0 || frame_rank[g] > best_rank) begin
          best      = g;
          best_rank = frame_rank[g];
        end
      end
    end
    return best;
  endfunction

  function automatic out_item_t replace_outcome(in_item_t it);
    out_item_t       r;
    int              f;
    int              v;
    int              tot;
    logic [CntW-1:0] delta;
    r = '0;
    f = int'(it.frame_number);
    case (it.command)
      CMD_ACCESS: begin
        access_cnt = access_cnt + 1'b1;
        if (f < NF) begin
          if (frame_list[f] == LST_NONE) begin
            move_to_front(f, LST_OLD);
            frame_stamp[f] = access_cnt;
          end else if (frame_list[f] == LST_YOUNG) begin
            drop_frame(f);
            move_to_front(f, LST_YOUNG);
          end else begin
            delta = access_cnt - frame_stamp[f];
            if (delta >= promo_thr) begin
              drop_frame(f);
              frame_stamp[f] = '0;
              move_to_front(f, LST_YOUNG);
            end
          end
        end
      end
      CMD_PIN: begin
        if (f < NF) frame_evict[f] = 1'b0;
      end
      CMD_UNPIN: begin
        if (f < NF) frame_evict[f] = 1'b1;
      end
      CMD_VICTIM: begin
        v = rearmost_evictable(LST_OLD);
        if (v < 0) v = rearmost_evictable(LST_YOUNG);
        if (v >= 0) begin
          drop_frame(v);
          frame_stamp[v] = '0;
          frame_evict[v] = 1'b0;
          r.victim_found = 1'b1;
          r.victim_frame = FrameW'(v);
        end
      end
      default: begin
      end
    endcase
    tot = 0;
    for (int g = 0; g < NF; g++) tot += int'(frame_evict[g]);
    r.evictable_total = TotalW'(tot);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lists();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        n_res++;
        if (expected_results.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          oldest = expected_results.pop_front();
          check_field("victim_found", 32'(oldest.victim_found), 32'(out_item.victim_found));
          check_field("victim_frame", 32'(oldest.victim_frame), 32'(out_item.victim_frame));
          check_field("evictable_total", 32'(oldest.evictable_total),
                      32'(out_item.evictable_total));
          if (oldest.victim_found) n_evict++;
        end
      end
      if (cfg_valid && cfg_ready) promo_thr = cfg_data;
      if (start && !busy) expected_results.push_back(replace_outcome(in_item));
    end
    fail_cnt    <= n_fail;
    pending     <= expected_results.size();
    result_cnt  <= n_res;
    evicted_cnt <= n_evict;
  end

endmodule

@@ dv/tb_young_old_lru_frame_replacer.sv @@
// ----------------------------------------------------------------------------
// tb_young_old_lru_frame_replacer
// Drives access, pin, unpin and victim commands into the frame replacer
// across several promotion thresholds: a directed opening, then random
// traffic on a narrow frame window with random sender gaps. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_young_old_lru_frame_replacer;
  import yolr_pkg::*;

  localparam int NF          = DefNumFrames;
  localparam int TAIL        = 2 * NF + 8;
  localparam int LIMIT       = 400000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 100;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CntW-1:0] cfg_data  = '0;
  in_item_t        in_item   = '0;
  logic            busy;
  logic            out_valid;
  logic            cfg_ready;
  out_item_t       out_item;

  int              fail_cnt;
  int              pending;
  int              result_cnt;
  int              evicted_cnt;
  int              cycles  = 0;
  int              n_items = 0;

  in_item_t        opening_items [$];
  logic [CntW-1:0] thr_set [N_PHASES];

  young_old_lru_frame_replacer #(.NUM_FRAMES(NF)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  yolr_checker #(.NF(NF)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_cnt    (fail_cnt),
    .pending     (pending),
    .result_cnt  (result_cnt),
    .evicted_cnt (evicted_cnt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t cmd_item(cmd_t c, int f);
    in_item_t it;
    it.command      = c;
    it.frame_number = FrameW'(f);
    return it;
  endfunction

  // mostly a 16-frame window so frames get re-accessed and promoted
  function automatic in_item_t random_cmd(int base);
    int   pick;
    int   f;
    cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 45)      c = CMD_ACCESS;
    else if (pick < 65) c = CMD_UNPIN;
    else if (pick < 75) c = CMD_PIN;
    else                c = CMD_VICTIM;
    if ($urandom_range(0, 99) < 75) f = base + $urandom_range(0, 15);
    else                            f = $urandom_range(0, NF - 1);
    return cmd_item(c, f);
  endfunction

  task automatic issue(input in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CntW-1:0] v);
    wait_drained();
    repeat (TAIL) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int base;

    thr_set = '{32'd0, 32'd1, 32'd4, 32'd12, 32'hFFFF_FFFF, 32'd0,
                32'h8000_0000, 32'd2};
    thr_set[5] = $urandom();

    // empty lists, untracked evictable frame, promotion at threshold 3,
    // pinned frames skipped, old list before young, no victim
    opening_items.push_back(cmd_item(CMD_VICTIM, 63));
    opening_items.push_back(cmd_item(CMD_PIN,    0));
    opening_items.push_back(cmd_item(CMD_UNPIN,  63));
    opening_items.push_back(cmd_item(CMD_VICTIM, 0));
    opening_items.push_back(cmd_item(CMD_ACCESS, 0));
    opening_items.push_back(cmd_item(CMD_ACCESS, 63));
    opening_items.push_back(cmd_item(CMD_ACCESS, 42));
    opening_items.push_back(cmd_item(CMD_ACCESS, 0));
    opening_items.push_back(cmd_item(CMD_ACCESS, 42));
    opening_items.push_back(cmd_item(CMD_UNPIN,  0));
    opening_items.push_back(cmd_item(CMD_UNPIN,  42));
    opening_items.push_back(cmd_item(CMD_UNPIN,  21));
    opening_items.push_back(cmd_item(CMD_PIN,    63));
    opening_items.push_back(cmd_item(CMD_VICTIM, 42));
    opening_items.push_back(cmd_item(CMD_VICTIM, 21));
    opening_items.push_back(cmd_item(CMD_VICTIM, 63));
    opening_items.push_back(cmd_item(CMD_UNPIN,  63));
    opening_items.push_back(cmd_item(CMD_VICTIM, 0));
    opening_items.push_back(cmd_item(CMD_ACCESS, 21));
    opening_items.push_back(cmd_item(CMD_ACCESS, 21));
    opening_items.push_back(cmd_item(CMD_ACCESS, 10));
    opening_items.push_back(cmd_item(CMD_ACCESS, 21));
    opening_items.push_back(cmd_item(CMD_ACCESS, 10));
    opening_items.push_back(cmd_item(CMD_UNPIN,  10));
    opening_items.push_back(cmd_item(CMD_VICTIM, 5));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_threshold(32'd3);
    foreach (opening_items[i]) begin
      issue(opening_items[i]);
      if ($urandom_range(0, 99) < 30) hold_off($urandom_range(1, 18));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_threshold(thr_set[p]);
      base = $urandom_range(0, NF - 16);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        issue(random_cmd(base));
        if (p == 2 && i == PHASE_ITEMS / 2)
          wait_drained();
        else if (p != N_PHASES - 1 && $urandom_range(0, 99) < 12)
          hold_off($urandom_range(1, 18));
      end
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);

    $display("run: %0d items, %0d results, %0d frames evicted", n_items, result_cnt,
             evicted_cnt);
    $display("run: %0d promotion thresholds incl. 0 and all-ones", N_PHASES + 1);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
